// ===== rtl/address_region_table_unit_macros.svh =====
// Assertion macros for the address region table.
`ifndef ADDRESS_REGION_TABLE_UNIT_MACROS_SVH
`define ADDRESS_REGION_TABLE_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ART_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ART_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/art_pkg.sv =====
// Package: operation and status codes, config indices and cell control types for the region table.
`default_nettype none
package art_pkg;
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_MAP     = 2'd1;
    localparam logic [1:0] OP_UNMAP   = 2'd2;
    localparam logic [1:0] OP_PROTECT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int CFG_SEARCH_BASE = 0;
    localparam int CFG_SEARCH_END  = 1;

    // Broadcast commands to the row of cells.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;
    localparam logic [1:0] CMD_PROT  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] prot;
    } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/address_region_table_unit.sv =====
// Top level: address region table with a row of slot cells and a search sequencer.
// Lookup, unmap, protect and explicit map pass the compare, decide and output states before the result is offered.
// An automatic map repeats compare, decide and align for each search step, up to 2*ENTRIES+4 steps.
// One word is in flight at a time; the next is taken the cycle after the result is taken.
// Reset (aresetn, synchronous, active low) clears the slots' valid bits and sets
// search_base and search_end to their defaults; the table needs no clearing pass.
`default_nettype none
`include "address_region_table_unit_macros.svh"
module address_region_table_unit #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BYTES = 4096,
    parameter int ADDR_BITS  = 48
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // op[1:0], addr, length, prot, flags, zero fill
    input  wire [((2 + ADDR_BITS + ADDR_BITS + 1 + 16) + 7) / 8 * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // status[1:0], placed_addr, hit_start, hit_length, hit_prot, hit_flags, zero fill
    output logic [((2 + 3 * ADDR_BITS + 1 + 16) + 7) / 8 * 8 - 1:0] m_tdata,
    input  wire                   cfg_we,
    input  wire [0:0]             cfg_index,
    input  wire [ADDR_BITS:0]     cfg_data
);
    localparam int AW   = ADDR_BITS;
    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ITW  = $clog2(2 * ENTRIES + 5);
    localparam int MAXIT = 2 * ENTRIES + 4;
    localparam int OUT_W = 2 + 3 * AW + 1 + 16;
    localparam int SW    = AW + 2;
    localparam logic [SW-1:0] PG = SW'(PAGE_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_ALIGN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  base_reg;
    logic [AW:0]    end_reg;

    logic [1:0]     op_reg;
    logic [AW-1:0]  addr_reg;
    logic [AW:0]    len_reg;
    logic [7:0]     prot_in_reg;
    logic [7:0]     flags_in_reg;
    logic [SW-1:0]  h_reg;
    logic [SW-1:0]  sz_reg;
    logic           searching_reg, wrapped_reg;
    logic [ITW-1:0] iter_reg;
    logic [SW-1:0]  aln_reg;

    logic           ov_valid_reg;
    logic [1:0]     o_status_reg;
    logic [AW-1:0]  o_placed_reg, o_hs_reg;
    logic [AW:0]    o_hl_reg;
    logic [7:0]     o_hp_reg, o_hf_reg;

    art_pkg::cell_ctl_t ctl;
    logic [ENTRIES-1:0] pull_sel;
    logic [AW-1:0]      probe_s;
    logic [AW:0]        probe_n;

    logic               c_valid   [ENTRIES];
    logic [AW-1:0]      c_start   [ENTRIES];
    logic [AW:0]        c_length  [ENTRIES];
    logic [7:0]         c_prot    [ENTRIES];
    logic [7:0]         c_flags   [ENTRIES];
    logic [AW+1:0]      c_end     [ENTRIES];
    logic [ENTRIES-1:0] hit_c, hit_o;
    logic               c_any_reg, o_any_reg;
    logic [IW-1:0]      c_idx_reg, o_idx_reg;

    // A rounded size of exactly 2**(AW+1) is always past the end, so its top bit never matters here.
    assign probe_s = (op_reg == art_pkg::OP_MAP && searching_reg) ? h_reg[AW-1:0] : addr_reg;
    assign probe_n = (op_reg == art_pkg::OP_MAP && searching_reg) ? sz_reg[AW:0] : len_reg;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic          nv;
            logic [AW-1:0] ns;
            logic [AW:0]   nl;
            logic [7:0]    np, nf;
            always_comb begin
                if (ctl.cmd == art_pkg::CMD_PUSH) begin
                    if (g == 0) begin
                        nv = 1'b1; ns = h_reg[AW-1:0]; nl = len_reg;
                        np = prot_in_reg; nf = flags_in_reg;
                    end else begin
                        nv = c_valid[(g == 0) ? 0 : g - 1];
                        ns = c_start[(g == 0) ? 0 : g - 1];
                        nl = c_length[(g == 0) ? 0 : g - 1];
                        np = c_prot[(g == 0) ? 0 : g - 1];
                        nf = c_flags[(g == 0) ? 0 : g - 1];
                    end
                end else begin
                    if (g == ENTRIES - 1) begin
                        nv = 1'b0; ns = '0; nl = '0; np = '0; nf = '0;
                    end else begin
                        nv = c_valid[(g == ENTRIES - 1) ? g : g + 1];
                        ns = c_start[(g == ENTRIES - 1) ? g : g + 1];
                        nl = c_length[(g == ENTRIES - 1) ? g : g + 1];
                        np = c_prot[(g == ENTRIES - 1) ? g : g + 1];
                        nf = c_flags[(g == ENTRIES - 1) ? g : g + 1];
                    end
                end
            end
            assign pull_sel[g] = (IW'(g) >= c_idx_reg);
            art_cell #(.AW(AW)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .sel(pull_sel[g]),
                .nb_valid(nv), .nb_start(ns), .nb_length(nl), .nb_prot(np), .nb_flags(nf),
                .probe_s(probe_s), .probe_n(probe_n),
                .valid(c_valid[g]), .start(c_start[g]), .length(c_length[g]),
                .prot(c_prot[g]), .flags(c_flags[g]),
                .hit_contain(hit_c[g]), .hit_overlap(hit_o[g]),
                .end_addr(c_end[g])
            );
        end
    endgenerate

    art_prio #(.N(ENTRIES), .IW(IW)) u_prio_c (
        .aclk(aclk), .req(hit_c), .any_reg(c_any_reg), .idx_reg(c_idx_reg));
    art_prio #(.N(ENTRIES), .IW(IW)) u_prio_o (
        .aclk(aclk), .req(hit_o), .any_reg(o_any_reg), .idx_reg(o_idx_reg));

    logic s_acc, m_acc;
    logic [SW-1:0] sum_h, aln_src;
    logic past;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !ov_valid_reg;
    assign sum_h    = h_reg + sz_reg;
    assign past     = (sum_h > {1'b0, end_reg}) || (h_reg[SW-1:AW] != 2'b00);

    // Next search candidate before page rounding.
    always_comb begin
        if (past) begin
            aln_src = {2'b00, base_reg};
        end else begin
            aln_src = c_end[o_idx_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl.cmd    = art_pkg::CMD_NONE;
        ctl.prot   = prot_in_reg;
        case (state_reg)
            S_IDLE:  if (s_acc) state_next = S_CMP;
            S_CMP:   state_next = S_DEC;
            S_DEC: begin
                state_next = S_OUT;
                case (op_reg)
                    art_pkg::OP_UNMAP: if (c_any_reg) ctl.cmd = art_pkg::CMD_PULL;
                    art_pkg::OP_PROTECT: ctl.cmd = art_pkg::CMD_PROT;
                    art_pkg::OP_MAP: begin
                        if (c_valid[ENTRIES-1]) begin
                        end else if (!searching_reg) begin
                            if (!o_any_reg) ctl.cmd = art_pkg::CMD_PUSH;
                        end else if (!o_any_reg && !past) begin
                            ctl.cmd = art_pkg::CMD_PUSH;
                        end else if (!(past && wrapped_reg) && iter_reg != ITW'(MAXIT - 1)) begin
                            state_next = S_ALIGN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALIGN: state_next = S_CMP;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ov_valid_reg <= 1'b0;
            base_reg     <= AW'(64'h1_0000_0000);
            end_reg      <= (AW+1)'(64'h8000_0000_0000);
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == 1'(art_pkg::CFG_SEARCH_BASE)) base_reg <= cfg_data[AW-1:0];
                else end_reg <= cfg_data;
            end
            if (m_acc) ov_valid_reg <= 1'b0;
            if (state_reg == S_OUT) ov_valid_reg <= 1'b1;
        end
        case (state_reg)
            S_IDLE: if (s_acc) begin
                op_reg        <= s_tdata[1:0];
                addr_reg      <= s_tdata[2 +: AW];
                len_reg       <= s_tdata[2 + AW +: AW + 1];
                prot_in_reg   <= s_tdata[3 + 2 * AW +: 8];
                flags_in_reg  <= s_tdata[11 + 2 * AW +: 8];
                searching_reg <= (s_tdata[2 +: AW] == '0);
                h_reg         <= (s_tdata[2 +: AW] == '0) ? {2'b00, base_reg}
                                                          : {2'b00, s_tdata[2 +: AW]};
                // Size rounded up to whole pages before the first probe.
                sz_reg        <= (({1'b0, s_tdata[2 + AW +: AW + 1]} + PG - 1) / PG) * PG;
                wrapped_reg   <= 1'b0;
                iter_reg      <= '0;
            end
            S_DEC: begin
                aln_reg <= aln_src + PG - 1;
                if (past) wrapped_reg <= 1'b1;
                iter_reg <= iter_reg + 1'b1;
                o_status_reg <= art_pkg::ST_OK;
                o_placed_reg <= '0;
                o_hs_reg <= '0; o_hl_reg <= '0; o_hp_reg <= '0; o_hf_reg <= '0;
                case (op_reg)
                    art_pkg::OP_LOOKUP: begin
                        if (c_any_reg) begin
                            o_hs_reg <= c_start[c_idx_reg];
                            o_hl_reg <= c_length[c_idx_reg];
                            o_hp_reg <= c_prot[c_idx_reg];
                            o_hf_reg <= c_flags[c_idx_reg];
                        end else o_status_reg <= art_pkg::ST_NOTFOUND;
                    end
                    art_pkg::OP_UNMAP: if (!c_any_reg) o_status_reg <= art_pkg::ST_NOTFOUND;
                    art_pkg::OP_MAP: begin
                        if (c_valid[ENTRIES-1]) o_status_reg <= art_pkg::ST_FULL;
                        else if (ctl.cmd == art_pkg::CMD_PUSH) o_placed_reg <= h_reg[AW-1:0];
                        else o_status_reg <= art_pkg::ST_NOSPACE;
                    end
                    default: begin
                    end
                endcase
            end
            S_ALIGN: begin
                h_reg <= (aln_reg / PG) * PG;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = ov_valid_reg;
    assign m_tdata  = {{(($bits(m_tdata)) - OUT_W){1'b0}}, o_hf_reg, o_hp_reg, o_hl_reg,
                       o_hs_reg, o_placed_reg, o_status_reg};

    `ART_ASSERT_IMP(a_one_item, aclk, aresetn, s_tready, state_reg == S_IDLE)
    `ART_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, ov_valid_reg, !s_tready)
    `ART_ASSERT_NEXT(a_out_follows, aclk, aresetn, state_reg == S_OUT, m_tvalid)
    `ART_ASSERT_IMP(a_iter_bound, aclk, aresetn, state_reg == S_ALIGN, iter_reg <= ITW'(MAXIT))
endmodule
`default_nettype wire

// ===== rtl/art_cell.sv =====
// One table slot: holds a region, compares it against the probe, shifts with neighbours.
`default_nettype none
module art_cell #(
    parameter int AW = 48
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire art_pkg::cell_ctl_t ctl,
    input  wire               sel,        // this slot is at or past the pull point
    input  wire               nb_valid,   // neighbour data for a shift
    input  wire [AW-1:0]      nb_start,
    input  wire [AW:0]        nb_length,
    input  wire [7:0]         nb_prot,
    input  wire [7:0]         nb_flags,
    input  wire [AW-1:0]      probe_s,
    input  wire [AW:0]        probe_n,
    output logic              valid,
    output logic [AW-1:0]     start,
    output logic [AW:0]       length,
    output logic [7:0]        prot,
    output logic [7:0]        flags,
    output logic              hit_contain,
    output logic              hit_overlap,
    output logic [AW+1:0]     end_addr
);
    logic            valid_reg;
    logic [AW-1:0]   start_reg;
    logic [AW:0]     length_reg;
    logic [7:0]      prot_reg;
    logic [7:0]      flags_reg;
    logic [AW+1:0]   pend;
    logic            hit_cover;

    always_comb begin
        end_addr    = {2'b00, start_reg} + {1'b0, length_reg};
        pend        = {2'b00, probe_s} + {1'b0, probe_n};
        hit_contain = valid_reg && (probe_s >= start_reg) && ({2'b00, probe_s} < end_addr);
        hit_overlap = valid_reg && !(({2'b00, probe_s} >= end_addr) ||
                                     (pend <= {2'b00, start_reg}));
        hit_cover   = valid_reg && (probe_s >= start_reg) && (pend <= end_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.cmd == art_pkg::CMD_PUSH ||
                     (ctl.cmd == art_pkg::CMD_PULL && sel)) begin
            valid_reg <= nb_valid;
        end
        case (ctl.cmd)
            art_pkg::CMD_PUSH: begin
                start_reg  <= nb_start;
                length_reg <= nb_length;
                prot_reg   <= nb_prot;
                flags_reg  <= nb_flags;
            end
            art_pkg::CMD_PULL: begin
                if (sel) begin
                    start_reg  <= nb_start;
                    length_reg <= nb_length;
                    prot_reg   <= nb_prot;
                    flags_reg  <= nb_flags;
                end
            end
            art_pkg::CMD_PROT: begin
                if (hit_cover) begin
                    prot_reg <= ctl.prot;
                end
            end
            default: begin
            end
        endcase
    end

    assign valid  = valid_reg;
    assign start  = start_reg;
    assign length = length_reg;
    assign prot   = prot_reg;
    assign flags  = flags_reg;
endmodule
`default_nettype wire

// ===== rtl/art_prio.sv =====
// Registered priority pick over the row: lowest slot index with a hit.
`default_nettype none
module art_prio #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  wire          aclk,
    input  wire [N-1:0]  req,
    output logic         any_reg,
    output logic [IW-1:0] idx_reg
);
    logic          any_next;
    logic [IW-1:0] idx_next;

    always_comb begin
        any_next = 1'b0;
        idx_next = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (req[i]) begin
                any_next = 1'b1;
                idx_next = IW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        any_reg <= any_next;
        idx_reg <= idx_next;
    end
endmodule
`default_nettype wire

// ===== tb/tb_address_region_table_unit.sv =====
// Self-checking testbench for the address region table unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_address_region_table_unit;

    localparam int SLOTS     = 16;
    localparam int PAGE      = 4096;
    localparam int IN_W      = 120;
    localparam int OUT_W     = 168;
    localparam longint AMASK = 64'hFFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 2_500_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] placed;
        logic [47:0] hit_start;
        logic [48:0] hit_length;
        logic [7:0]  hit_prot;
        logic [7:0]  hit_flags;
    } region_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    wire              s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    wire              m_tvalid;
    logic             m_tready = 1'b0;
    wire [OUT_W-1:0]  m_tdata;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [48:0]      cfg_data = '0;

    address_region_table_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // Shadow copy of the table and the placement window.
    logic          tbl_valid [SLOTS];
    logic [63:0]   tbl_start [SLOTS];
    logic [63:0]   tbl_len   [SLOTS];
    logic [7:0]    tbl_prot  [SLOTS];
    logic [7:0]    tbl_flags [SLOTS];
    logic [63:0]   win_base = 64'h1_0000_0000;
    logic [63:0]   win_limit = 64'h8000_0000_0000;

    region_result_t pending_results[$];
    int  mismatches = 0;
    longint cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;

    function automatic logic [63:0] page_up(logic [63:0] v);
        return ((v + PAGE - 1) / PAGE) * PAGE;
    endfunction

    function automatic int overlap_slot(logic [63:0] s, logic [63:0] n);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && !(s >= tbl_start[i] + tbl_len[i] || s + n <= tbl_start[i]))
                return i;
        end
        return -1;
    endfunction

    function automatic int containing_slot(logic [63:0] a);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && a >= tbl_start[i] && a < tbl_start[i] + tbl_len[i])
                return i;
        end
        return -1;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) n++;
        return n;
    endfunction

    // First-fit placement: jump past the newest collision, wrap to the base once.
    function automatic bit place_region(logic [63:0] len, output logic [63:0] where);
        logic [63:0] sz, h;
        bit wrapped, past;
        int c;
        sz = page_up(len);
        h = win_base;
        wrapped = 0;
        where = 0;
        for (int it = 0; it < 2 * SLOTS + 4; it++) begin
            c = overlap_slot(h, sz);
            past = (h + sz > win_limit) || (h > AMASK);
            if (c < 0 && !past) begin
                where = h;
                return 1;
            end
            if (past) begin
                if (wrapped) return 0;
                h = win_base;
                wrapped = 1;
            end else begin
                h = tbl_start[c] + tbl_len[c];
            end
            h = page_up(h);
        end
        return 0;
    endfunction

    function automatic region_result_t apply_request(logic [1:0] op, logic [47:0] addr,
                                                     logic [48:0] len, logic [7:0] prot,
                                                     logic [7:0] flags);
        region_result_t r;
        logic [63:0] where;
        bit ok;
        int k;
        r = '0;
        case (op)
            art_pkg::OP_LOOKUP: begin
                k = containing_slot({16'd0, addr});
                if (k < 0) begin
                    r.status = art_pkg::ST_NOTFOUND;
                end else begin
                    r.hit_start  = tbl_start[k][47:0];
                    r.hit_length = tbl_len[k][48:0];
                    r.hit_prot   = tbl_prot[k];
                    r.hit_flags  = tbl_flags[k];
                end
            end
            art_pkg::OP_MAP: begin
                if (tbl_valid[SLOTS-1]) begin
                    r.status = art_pkg::ST_FULL;
                end else begin
                    where = {16'd0, addr};
                    if (addr == 0) ok = place_region({15'd0, len}, where);
                    else ok = overlap_slot(where, {15'd0, len}) < 0;
                    if (!ok) begin
                        r.status = art_pkg::ST_NOSPACE;
                    end else begin
                        for (int i = SLOTS - 1; i > 0; i--) begin
                            tbl_valid[i] = tbl_valid[i-1];
                            tbl_start[i] = tbl_start[i-1];
                            tbl_len[i]   = tbl_len[i-1];
                            tbl_prot[i]  = tbl_prot[i-1];
                            tbl_flags[i] = tbl_flags[i-1];
                        end
                        tbl_valid[0] = 1'b1;
                        tbl_start[0] = where & AMASK;
                        tbl_len[0]   = {15'd0, len};
                        tbl_prot[0]  = prot;
                        tbl_flags[0] = flags;
                        r.placed = where[47:0];
                    end
                end
            end
            art_pkg::OP_UNMAP: begin
                k = containing_slot({16'd0, addr});
                if (k < 0) begin
                    r.status = art_pkg::ST_NOTFOUND;
                end else begin
                    for (int i = k; i < SLOTS - 1; i++) begin
                        tbl_valid[i] = tbl_valid[i+1];
                        tbl_start[i] = tbl_start[i+1];
                        tbl_len[i]   = tbl_len[i+1];
                        tbl_prot[i]  = tbl_prot[i+1];
                        tbl_flags[i] = tbl_flags[i+1];
                    end
                    tbl_valid[SLOTS-1] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && addr >= tbl_start[i] &&
                        addr + len <= tbl_start[i] + tbl_len[i])
                        tbl_prot[i] = prot;
                end
            end
        endcase
        return r;
    endfunction

    // Offers one word, with a random gap first, and records its expected result.
    task automatic send_request(logic [1:0] op, logic [47:0] addr, logic [48:0] len,
                                logic [7:0] prot, logic [7:0] flags);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, flags, prot, len, addr, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_request(op, addr, len, prot, flags));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(logic [47:0] base, logic [48:0] limit);
        drain();
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 1'(art_pkg::CFG_SEARCH_BASE);
        cfg_data <= {1'b0, base};
        @(posedge aclk);
        cfg_index <= 1'(art_pkg::CFG_SEARCH_END);
        cfg_data <= limit;
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_base = {16'd0, base};
        win_limit = {15'd0, limit};
        @(posedge aclk);
    endtask

    // Zero-length regions cannot be unmapped and stay behind.
    task automatic clear_table();
        int k;
        forever begin
            k = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (tbl_valid[i] && tbl_len[i] != 0) k = i;
            if (k < 0) break;
            send_request(art_pkg::OP_UNMAP, tbl_start[k][47:0], '0, '0, '0);
        end
    endtask

    task automatic test_basic_ops();
        send_request(art_pkg::OP_LOOKUP, '0, '0, '0, '0);
        send_request(art_pkg::OP_MAP, 48'h1000, 49'h2000, 8'hFF, 8'h00);
        send_request(art_pkg::OP_LOOKUP, 48'h2FFF, '0, '0, '0);
        send_request(art_pkg::OP_LOOKUP, 48'h3000, '0, '0, '0);
        send_request(art_pkg::OP_MAP, 48'h2000, 49'h100, 8'h01, 8'h02);
        send_request(art_pkg::OP_PROTECT, 48'h1800, 49'h800, 8'h5A, '0);
        send_request(art_pkg::OP_PROTECT, 48'h2800, 49'h1000, 8'hA5, '0);
        send_request(art_pkg::OP_LOOKUP, 48'h1000, '0, '0, '0);
        send_request(art_pkg::OP_UNMAP, 48'h9000, '0, '0, '0);
        send_request(art_pkg::OP_MAP, 48'h8000, '0, 8'h03, 8'hFF);
        send_request(art_pkg::OP_LOOKUP, 48'h8000, '0, '0, '0);
        send_request(art_pkg::OP_MAP, 48'hFFFF_FFFF_FFFF, 49'h1_0000_0000_0000, 8'h00, 8'hFF);
        send_request(art_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
        send_request(art_pkg::OP_MAP, 48'h100_0000_0000, 49'h1_FFFF_FFFF_FFFF, 8'hFF, 8'hFF);
        send_request(art_pkg::OP_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
        send_request(art_pkg::OP_UNMAP, 48'h1000, '0, '0, '0);
    endtask

    task automatic test_search();
        send_request(art_pkg::OP_MAP, '0, 49'd1, 8'h11, 8'h22);
        send_request(art_pkg::OP_MAP, '0, 49'd5000, 8'h33, 8'h44);
        send_request(art_pkg::OP_LOOKUP, 48'h1_0000_1000, '0, '0, '0);
        write_window(48'h10003, 49'h10003 + 3 * PAGE);
        clear_table();
        repeat (4) send_request(art_pkg::OP_MAP, '0, 49'd4096, 8'h77, 8'h88);
        write_window(48'h20000, 49'd0);
        send_request(art_pkg::OP_MAP, '0, 49'd1, '0, '0);
        write_window(48'hFFFF_FFFF_FFFF, 49'h1_0000_0000_0000);
        send_request(art_pkg::OP_MAP, '0, 49'd1, '0, '0);
        write_window('0, 49'h1_0000_0000_0000);
        send_request(art_pkg::OP_MAP, '0, 49'd4096, 8'h9, 8'h6);
        clear_table();
    endtask

    task automatic test_full_table();
        int n;
        n = used_slots();
        for (int i = 0; i <= SLOTS - n; i++)
            send_request(art_pkg::OP_MAP, 48'h40_0000 + i * PAGE, 49'd4096, i[7:0], ~i[7:0]);
        clear_table();
    endtask

    task automatic test_random(int count, int tx_pct, int rx_pct,
                               logic [47:0] base, logic [48:0] limit);
        logic [1:0]  op;
        logic [47:0] addr;
        logic [48:0] len;
        int n, k, sel;
        write_window(base, limit);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        clear_table();
        for (int it = 0; it < count; it++) begin
            if (it == count / 2) drain();
            n = used_slots();
            sel = $urandom_range(0, 99);
            op = sel < 40 ? art_pkg::OP_MAP : sel < 65 ? art_pkg::OP_UNMAP :
                 sel < 85 ? art_pkg::OP_LOOKUP : art_pkg::OP_PROTECT;
            k = n > 0 ? $urandom_range(0, n - 1) : 0;
            sel = $urandom_range(0, 99);
            if (n > 0 && sel < 45 && tbl_len[k] != 0)
                addr = 48'(tbl_start[k] + ({$urandom, $urandom} % tbl_len[k]));
            else if (sel < 80)
                addr = base + $urandom_range(0, 40) * PAGE + ($urandom_range(0, 3) == 0 ?
                       $urandom_range(1, PAGE - 1) : 0);
            else if (sel < 92)
                addr = 48'($urandom_range(0, 1 << 20));
            else
                addr = 48'({$urandom, $urandom});
            sel = $urandom_range(0, 99);
            if (sel < 85) len = 49'($urandom_range(1, 3 * PAGE));
            else if (sel < 97) len = 49'($urandom_range(1, 16) * PAGE);
            else len = 49'({$urandom, $urandom});
            if (len == 0) len = 49'd1;
            if (op == art_pkg::OP_MAP && $urandom_range(0, 1) == 0) addr = '0;
            if (op == art_pkg::OP_PROTECT && n > 0 && $urandom_range(0, 1) == 0 &&
                tbl_len[k] > 1) begin
                addr = tbl_start[k][47:0];
                len = 49'(tbl_len[k] - $urandom_range(0, 1));
            end
            send_request(op, addr, len, 8'($urandom), 8'($urandom));
        end
        drain();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    always @(posedge aclk) begin
        m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        region_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[49:2], m_tdata[97:50], m_tdata[146:98],
                    m_tdata[154:147], m_tdata[162:155]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.placed != want.placed ||
                    got.hit_start != want.hit_start || got.hit_length != want.hit_length ||
                    got.hit_prot != want.hit_prot || got.hit_flags != want.hit_flags) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: status %0d/%0d placed %h/%h start %h/%h",
                                  " len %h/%h prot %h/%h flags %h/%h"},
                                 want.status, got.status, want.placed, got.placed,
                                 want.hit_start, got.hit_start, want.hit_length, got.hit_length,
                                 want.hit_prot, got.hit_prot, want.hit_flags, got.hit_flags);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL address_region_table_unit");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_len[i]   = '0;
            tbl_prot[i]  = '0;
            tbl_flags[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_search();
        test_full_table();
        test_random(430, 0, 0, 48'h10000, 49'h10000 + 40 * PAGE);
        test_random(430, 83, 0, 48'h12345, 49'h12345 + 24 * PAGE);
        test_random(430, 0, 83, 48'h1_0000_0000, 49'h8000_0000_0000);
        test_random(430, 7, 7, 48'h0, 49'h40 * PAGE);
        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS address_region_table_unit");
        else
            $display("FAIL address_region_table_unit");
        $finish;
    end
endmodule
`default_nettype wire
